@@ hdl/sampled_threshold_alarm_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sampled threshold alarm
// Concurrent checks clocked on clock and disabled while reset is high.
// Empty bodies when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SAMPLED_THRESHOLD_ALARM_TOP_ASSERT_SVH
`define SAMPLED_THRESHOLD_ALARM_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define STA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sta: same-cycle check failed");

// condition implies consequence in the next cycle
`define STA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sta: next-cycle check failed");

`else

`define STA_ASSERT_SAME(label, ante, cons)
`define STA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hdl/sta_pkg.sv @@
// ---------------------------------------------------------------------------
// sta_pkg
// Types and constants shared by the sampled threshold alarm modules.
// ---------------------------------------------------------------------------
package sta_pkg;

   // countdown step per tick
   localparam logic [15:0] TICK_STEP = 16'd1;

   // start-up mode codes (any other code allows either alarm first)
   localparam logic [1:0] STARTUP_RISING  = 2'd0;
   localparam logic [1:0] STARTUP_FALLING = 2'd1;

   // event kind that disables an alarm
   localparam logic [1:0] EVENT_NONE = 2'd0;

   // last alarm seen
   typedef enum logic [1:0] {
      ALARM_NONE = 2'd0,
      ALARM_RISE = 2'd1,
      ALARM_FALL = 2'd2
   } alarm_type;

   // register index, word address paddr[4:2]
   typedef enum logic [2:0] {
      REG_INTERVAL       = 3'd0,
      REG_SAMPLE_KIND    = 3'd1,
      REG_STARTUP_MODE   = 3'd2,
      REG_RISING_THRESH  = 3'd3,
      REG_FALLING_THRESH = 3'd4,
      REG_RISING_EVENT   = 3'd5,
      REG_FALLING_EVENT  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [15:0]        interval;
      logic               sample_kind;
      logic [1:0]         startup_mode;
      logic signed [31:0] rising_threshold;
      logic signed [31:0] falling_threshold;
      logic [1:0]         rising_event_kind;
      logic [1:0]         falling_event_kind;
   } cfg_type;

   typedef struct packed {
      logic [62:0] counter_value;
      logic        counter_valid;
   } req_type;

   typedef struct packed {
      logic               sampled;
      logic signed [63:0] sample_value;
      logic               rising_fired;
      logic               falling_fired;
      logic [1:0]         rising_action;
      logic [1:0]         falling_action;
   } rsp_type;

endpackage

@@ hdl/sta_csr.sv @@
// ---------------------------------------------------------------------------
// sta_csr
// APB-style configuration registers with read back, zero wait states.
// ---------------------------------------------------------------------------
module sta_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output sta_pkg::cfg_type cfg
);

   sta_pkg::cfg_type      cfg_ff;
   sta_pkg::cfg_type      cfg_in;
   sta_pkg::reg_index_type reg_index;
   logic                  wr_en;

   assign pready    = 1'b1;
   assign reg_index = sta_pkg::reg_index_type'(paddr[4:2]);
   assign wr_en     = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            sta_pkg::REG_INTERVAL:       cfg_in.interval           = pwdata[15:0];
            sta_pkg::REG_SAMPLE_KIND:    cfg_in.sample_kind        = pwdata[0];
            sta_pkg::REG_STARTUP_MODE:   cfg_in.startup_mode       = pwdata[1:0];
            sta_pkg::REG_RISING_THRESH:  cfg_in.rising_threshold   = pwdata;
            sta_pkg::REG_FALLING_THRESH: cfg_in.falling_threshold  = pwdata;
            sta_pkg::REG_RISING_EVENT:   cfg_in.rising_event_kind  = pwdata[1:0];
            sta_pkg::REG_FALLING_EVENT:  cfg_in.falling_event_kind = pwdata[1:0];
            default: ;
         endcase
      end
   end

   // read decode
   always_comb begin
      prdata = 32'd0;
      unique case (reg_index)
         sta_pkg::REG_INTERVAL:       prdata = {16'd0, cfg_ff.interval};
         sta_pkg::REG_SAMPLE_KIND:    prdata = {31'd0, cfg_ff.sample_kind};
         sta_pkg::REG_STARTUP_MODE:   prdata = {30'd0, cfg_ff.startup_mode};
         sta_pkg::REG_RISING_THRESH:  prdata = cfg_ff.rising_threshold;
         sta_pkg::REG_FALLING_THRESH: prdata = cfg_ff.falling_threshold;
         sta_pkg::REG_RISING_EVENT:   prdata = {30'd0, cfg_ff.rising_event_kind};
         sta_pkg::REG_FALLING_EVENT:  prdata = {30'd0, cfg_ff.falling_event_kind};
         default:                     prdata = 32'd0;
      endcase
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval           <= 16'd1;
         cfg_ff.sample_kind        <= 1'b0;
         cfg_ff.startup_mode       <= 2'd2;
         cfg_ff.rising_threshold   <= 32'sd0;
         cfg_ff.falling_threshold  <= 32'sd0;
         cfg_ff.rising_event_kind  <= sta_pkg::EVENT_NONE;
         cfg_ff.falling_event_kind <= sta_pkg::EVENT_NONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/sta_core.sv @@
// ---------------------------------------------------------------------------
// sta_core
// Tick countdown, sampling and rising/falling alarm evaluation with
// hysteresis. State advances once per transaction moved to the output.
// ---------------------------------------------------------------------------
`include "sampled_threshold_alarm_top_assert.svh"

module sta_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  sta_pkg::cfg_type cfg,
   input  sta_pkg::req_type item,
   output sta_pkg::rsp_type result
);

   logic [15:0]         ticks_left_ff, ticks_left_in;
   logic                primed_ff, primed_in;
   logic [63:0]         prev_abs_ff, prev_abs_in;
   logic [63:0]         last_sample_ff, last_sample_in;
   sta_pkg::alarm_type  last_alarm_ff, last_alarm_in;
   logic                both_armed_ff, both_armed_in;

   logic                take;
   logic                prime_en;
   logic                sample_en;
   logic [63:0]         cur_abs;
   logic signed [63:0]  sample_calc;
   logic signed [63:0]  rising_th;
   logic signed [63:0]  falling_th;
   logic                rise_hit;
   logic                fall_hit;

   // countdown: sample when expired or not yet primed
   assign take          = (ticks_left_ff <= sta_pkg::TICK_STEP) || !primed_ff;
   assign ticks_left_in = take ? cfg.interval : ticks_left_ff - sta_pkg::TICK_STEP;

   assign prime_en  = take && item.counter_valid && !primed_ff;
   assign sample_en = take && item.counter_valid && primed_ff;

   // absolute value or wrapped delta
   assign cur_abs     = {1'b0, item.counter_value};
   assign sample_calc = cfg.sample_kind ? cur_abs - prev_abs_ff : cur_abs;

   assign rising_th  = {{32{cfg.rising_threshold[31]}}, cfg.rising_threshold};
   assign falling_th = {{32{cfg.falling_threshold[31]}}, cfg.falling_threshold};

   // rising check first; a rising fire lifts the start-up limit for falling
   assign rise_hit = sample_en
                  && (both_armed_ff || cfg.startup_mode != sta_pkg::STARTUP_FALLING)
                  && (sample_calc >= rising_th)
                  && (last_alarm_ff != sta_pkg::ALARM_RISE)
                  && (cfg.rising_event_kind != sta_pkg::EVENT_NONE);

   assign fall_hit = sample_en
                  && (both_armed_ff || rise_hit
                      || cfg.startup_mode != sta_pkg::STARTUP_RISING)
                  && (sample_calc <= falling_th)
                  && (rise_hit || last_alarm_ff != sta_pkg::ALARM_FALL)
                  && (cfg.falling_event_kind != sta_pkg::EVENT_NONE);

   // next state
   always_comb begin
      primed_in      = primed_ff;
      prev_abs_in    = prev_abs_ff;
      last_sample_in = last_sample_ff;
      if (prime_en) begin
         primed_in      = 1'b1;
         prev_abs_in    = cur_abs;
         last_sample_in = 64'd0;
      end else if (sample_en) begin
         prev_abs_in    = cur_abs;
         last_sample_in = sample_calc;
      end
      if (fall_hit) begin
         last_alarm_in = sta_pkg::ALARM_FALL;
      end else if (rise_hit) begin
         last_alarm_in = sta_pkg::ALARM_RISE;
      end else begin
         last_alarm_in = last_alarm_ff;
      end
      both_armed_in = both_armed_ff || rise_hit || fall_hit;
   end

   // result of this transaction
   always_comb begin
      result.sampled        = sample_en;
      result.sample_value   = last_sample_in;
      result.rising_fired   = rise_hit;
      result.falling_fired  = fall_hit;
      result.rising_action  = rise_hit ? cfg.rising_event_kind : sta_pkg::EVENT_NONE;
      result.falling_action = fall_hit ? cfg.falling_event_kind : sta_pkg::EVENT_NONE;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_left_ff  <= 16'd0;
         primed_ff      <= 1'b0;
         prev_abs_ff    <= 64'd0;
         last_sample_ff <= 64'd0;
         last_alarm_ff  <= sta_pkg::ALARM_NONE;
         both_armed_ff  <= 1'b0;
      end else if (advance) begin
         ticks_left_ff  <= ticks_left_in;
         primed_ff      <= primed_in;
         prev_abs_ff    <= prev_abs_in;
         last_sample_ff <= last_sample_in;
         last_alarm_ff  <= last_alarm_in;
         both_armed_ff  <= both_armed_in;
      end
   end

   // checks
   `STA_ASSERT_NEXT(a_primed_sticks, primed_ff, primed_ff)
   `STA_ASSERT_SAME(a_sample_after_prime, result.sampled, primed_ff)
   `STA_ASSERT_NEXT(a_fire_arms, advance && (rise_hit || fall_hit), both_armed_ff)
   `STA_ASSERT_NEXT(a_rise_recorded, advance && rise_hit && !fall_hit,
                    last_alarm_ff == sta_pkg::ALARM_RISE)
   `STA_ASSERT_NEXT(a_unprimed_reload, advance && !primed_ff,
                    ticks_left_ff == $past(cfg.interval))

endmodule

@@ hdl/sampled_threshold_alarm_top.sv @@
// ---------------------------------------------------------------------------
// sampled_threshold_alarm_top
// Threshold alarm on a sampled counter: per-tick countdown, absolute or
// delta samples, rising/falling alarms with hysteresis and start-up mode.
//
//   channel   direction  handshake                      payload
//   req       in         req_valid / req_ready          req_payload (req_type)
//   rsp       out        rsp_valid / rsp_ready          rsp_payload (rsp_type)
//   csr       in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One transaction per cycle sustained while rsp_ready holds; a request passes
// through the input register, then the result register, before rsp_valid.
// The alarm state updates as a transaction moves from the input register
// to the result register, so the 64-bit subtract and compare set the path.
// A stalled result holds the input register; a new transaction still enters
// in the cycle the result is taken. Reset clears state and valid flags, not payloads.
// ---------------------------------------------------------------------------
module sampled_threshold_alarm_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sta_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sta_pkg::rsp_type rsp_payload,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   sta_pkg::cfg_type cfg;
   sta_pkg::rsp_type result;

   logic             in_valid_ff, in_valid_in;
   sta_pkg::req_type in_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   sta_pkg::rsp_type rsp_payload_ff;
   logic             advance;
   logic             req_accept;

   // configuration registers
   sta_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // alarm evaluation and state
   sta_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .item    (in_item_ff),
      .result  (result)
   );

   // pipeline control
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_accept  = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= result;
      end
   end

endmodule

@@ tb/tb_sampled_threshold_alarm_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sampled_threshold_alarm_top
// Drives timer ticks into the threshold alarm and checks every report
// against an in-bench prediction of countdown, priming, absolute and delta
// samples, hysteresis and start-up mode. A short directed run is followed
// by random phases with different register settings and handshake pressure.
// ---------------------------------------------------------------------------
module tb_sampled_threshold_alarm_top;

   localparam int          STALL_LIMIT      = 2000;
   localparam int          NUM_PHASES       = 9;
   localparam int          RANDOM_PER_PHASE = 150;
   localparam logic [62:0] COUNT_MAX        = '1;
   localparam logic [1:0]  STARTUP_EITHER   = 2'd2;
   localparam logic [1:0]  STARTUP_CODE3    = 2'd3;
   localparam logic        SAMPLE_ABSOLUTE  = 1'b0;
   localparam logic        SAMPLE_DELTA     = 1'b1;
   localparam logic [1:0]  EVENT_LOG        = 2'd1;
   localparam logic [1:0]  EVENT_TRAP       = 2'd2;
   localparam logic [1:0]  EVENT_BOTH       = 2'd3;

   // tracks alarm state per tick and holds the reports still owed
   class alarm_tracker;
      sta_pkg::cfg_type   cfg;
      logic [17:0]        ticks_left;
      bit                 primed;
      logic [63:0]        prev_abs;
      logic [63:0]        last_sample;
      sta_pkg::alarm_type last_alarm;
      bit                 both_armed;
      sta_pkg::rsp_type   expected_reports[$];
      int                 errors;

      function new();
         cfg              = '0;
         cfg.interval     = 16'd1;
         cfg.startup_mode = STARTUP_EITHER;
         ticks_left       = '0;
         primed           = 1'b0;
         prev_abs         = '0;
         last_sample      = '0;
         last_alarm       = sta_pkg::ALARM_NONE;
         both_armed       = 1'b0;
         errors           = 0;
      endfunction

      function void set_register(sta_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            sta_pkg::REG_INTERVAL:       cfg.interval = value[15:0];
            sta_pkg::REG_SAMPLE_KIND:    cfg.sample_kind = value[0];
            sta_pkg::REG_STARTUP_MODE:   cfg.startup_mode = value[1:0];
            sta_pkg::REG_RISING_THRESH:  cfg.rising_threshold = value;
            sta_pkg::REG_FALLING_THRESH: cfg.falling_threshold = value;
            sta_pkg::REG_RISING_EVENT:   cfg.rising_event_kind = value[1:0];
            sta_pkg::REG_FALLING_EVENT:  cfg.falling_event_kind = value[1:0];
            default: ;
         endcase
      endfunction

      // advance one tick and queue the report it must produce
      function void note_tick(sta_pkg::req_type item);
         logic [63:0]        cur;
         logic signed [63:0] s;
         logic signed [63:0] rise_lim;
         logic signed [63:0] fall_lim;
         bit                 take;
         sta_pkg::rsp_type   rpt;
         cur  = {1'b0, item.counter_value};
         rpt  = '0;
         take = (ticks_left <= {2'b00, sta_pkg::TICK_STEP}) || !primed;
         if (take) begin
            ticks_left = {2'b00, cfg.interval};
         end else begin
            ticks_left = ticks_left - {2'b00, sta_pkg::TICK_STEP};
         end
         if (take && item.counter_valid) begin
            if (!primed) begin
               prev_abs    = cur;
               last_sample = '0;
               primed      = 1'b1;
            end else begin
               last_sample = cfg.sample_kind ? cur - prev_abs : cur;
               prev_abs    = cur;
               rpt.sampled = 1'b1;
               s           = last_sample;
               rise_lim    = 64'(cfg.rising_threshold);
               fall_lim    = 64'(cfg.falling_threshold);
               // rising first, it lifts the start-up limit for falling
               if ((both_armed || cfg.startup_mode != sta_pkg::STARTUP_FALLING) &&
                   s >= rise_lim && last_alarm != sta_pkg::ALARM_RISE &&
                   cfg.rising_event_kind != sta_pkg::EVENT_NONE) begin
                  rpt.rising_fired  = 1'b1;
                  rpt.rising_action = cfg.rising_event_kind;
                  last_alarm        = sta_pkg::ALARM_RISE;
                  both_armed        = 1'b1;
               end
               if ((both_armed || cfg.startup_mode != sta_pkg::STARTUP_RISING) &&
                   s <= fall_lim && last_alarm != sta_pkg::ALARM_FALL &&
                   cfg.falling_event_kind != sta_pkg::EVENT_NONE) begin
                  rpt.falling_fired  = 1'b1;
                  rpt.falling_action = cfg.falling_event_kind;
                  last_alarm         = sta_pkg::ALARM_FALL;
                  both_armed         = 1'b1;
               end
            end
         end
         rpt.sample_value = last_sample;
         expected_reports.push_back(rpt);
      endfunction

      function void check_report(sta_pkg::rsp_type got);
         sta_pkg::rsp_type want;
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: report with none expected, got sampled=%0b value=%0d",
                     $time, got.sampled, got.sample_value);
            return;
         end
         want = expected_reports.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: report mismatch expected s=%0b v=%0d r=%0b/%0d f=%0b/%0d",
                     $time, want.sampled, want.sample_value, want.rising_fired,
                     want.rising_action, want.falling_fired, want.falling_action);
            $display("%0t:                  actual s=%0b v=%0d r=%0b/%0d f=%0b/%0d",
                     $time, got.sampled, got.sample_value, got.rising_fired,
                     got.rising_action, got.falling_fired, got.falling_action);
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   sta_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   sta_pkg::rsp_type rsp_payload;
   logic             psel        = 1'b0;
   logic             penable     = 1'b0;
   logic             pwrite      = 1'b0;
   logic [4:0]       paddr       = '0;
   logic [31:0]      pwdata      = '0;
   logic [31:0]      prdata;
   logic             pready;

   alarm_tracker     tracker = new();
   sta_pkg::cfg_type active_cfg = '0;
   int unsigned      src_idle_pct   = 0;
   int unsigned      sink_stall_pct = 0;
   int               stall_cycles   = 0;

   sampled_threshold_alarm_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // check each report transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_report(rsp_payload);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic sta_pkg::cfg_type make_cfg(logic [15:0] interval, logic kind,
                                                 logic [1:0] startup,
                                                 logic [31:0] rise, logic [31:0] fall,
                                                 logic [1:0] rise_kind,
                                                 logic [1:0] fall_kind);
      sta_pkg::cfg_type c;
      c.interval           = interval;
      c.sample_kind        = kind;
      c.startup_mode       = startup;
      c.rising_threshold   = rise;
      c.falling_threshold  = fall;
      c.rising_event_kind  = rise_kind;
      c.falling_event_kind = fall_kind;
      return c;
   endfunction

   // register setting for a random phase, extremes in some phases
   function automatic sta_pkg::cfg_type random_setting(int p);
      sta_pkg::cfg_type c;
      int               fall_v;
      int               rise_v;
      case ($urandom_range(4))
         0:       c.interval = 16'd0;
         1:       c.interval = 16'd1;
         default: c.interval = 16'($urandom_range(2, 6));
      endcase
      if (p == NUM_PHASES - 1) begin
         c.interval = 16'hFFFF;
      end
      c.sample_kind        = p[0] ? SAMPLE_DELTA : SAMPLE_ABSOLUTE;
      c.startup_mode       = 2'($urandom_range(3));
      c.rising_event_kind  = 2'($urandom_range(3));
      c.falling_event_kind = 2'($urandom_range(3));
      fall_v = int'($urandom_range(2000)) - 1000;
      rise_v = fall_v + int'($urandom_range(1500)) - 200;
      c.rising_threshold  = rise_v;
      c.falling_threshold = fall_v;
      if (p == 2) begin
         c.rising_threshold  = 32'h7FFF_FFFF;
         c.falling_threshold = 32'h8000_0000;
      end else if (p == 4) begin
         c.rising_threshold  = $urandom;
         c.falling_threshold = $urandom;
      end else if (p == 5) begin
         c.rising_threshold  = 32'h8000_0000;
         c.falling_threshold = 32'h7FFF_FFFF;
      end
      return c;
   endfunction

   // counter value steered toward the thresholds, with some noise
   function automatic logic [62:0] pick_counter();
      logic signed [31:0] thresh;
      logic signed [63:0] target;
      logic [62:0]        v;
      case ($urandom_range(9))
         0: v = 63'({$urandom, $urandom});
         1: v = $urandom_range(1) ? COUNT_MAX : '0;
         default: begin
            thresh = $urandom_range(1) ? active_cfg.rising_threshold
                                       : active_cfg.falling_threshold;
            target = 64'(thresh) + 64'(int'($urandom_range(8)) - 4);
            if (active_cfg.sample_kind == SAMPLE_DELTA) begin
               v = tracker.prev_abs[62:0] + target[62:0];
            end else begin
               v = (target < 0) ? 63'($urandom_range(50)) : target[62:0];
            end
         end
      endcase
      return v;
   endfunction

   task automatic csr_write(input sta_pkg::reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   task automatic load_config(input sta_pkg::cfg_type c);
      csr_write(sta_pkg::REG_INTERVAL, {16'd0, c.interval});
      csr_write(sta_pkg::REG_SAMPLE_KIND, {31'd0, c.sample_kind});
      csr_write(sta_pkg::REG_STARTUP_MODE, {30'd0, c.startup_mode});
      csr_write(sta_pkg::REG_RISING_THRESH, c.rising_threshold);
      csr_write(sta_pkg::REG_FALLING_THRESH, c.falling_threshold);
      csr_write(sta_pkg::REG_RISING_EVENT, {30'd0, c.rising_event_kind});
      csr_write(sta_pkg::REG_FALLING_EVENT, {30'd0, c.falling_event_kind});
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      active_cfg = c;
   endtask

   // one tick transaction, with random idle cycles ahead of it
   task automatic send_tick(input logic valid_bit, input logic [62:0] value);
      sta_pkg::req_type item;
      item.counter_value = value;
      item.counter_valid = valid_bit;
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_tick(item);
   endtask

   // stop sending until every report has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) begin
            drain();
         end
         send_tick($urandom_range(11) != 0, pick_counter());
      end
   endtask

   // main sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // start-up limited to falling, priming, invalid ticks, hysteresis
      load_config(make_cfg(16'd1, SAMPLE_ABSOLUTE, sta_pkg::STARTUP_FALLING, 32'd100, 32'd10,
                           EVENT_LOG, EVENT_TRAP));
      send_tick(1'b0, COUNT_MAX);
      send_tick(1'b1, COUNT_MAX);
      send_tick(1'b1, 63'd200);
      send_tick(1'b1, 63'd300);
      send_tick(1'b0, 63'd0);
      send_tick(1'b1, 63'd5);
      send_tick(1'b1, 63'd0);
      send_tick(1'b1, 63'd200);
      drain();

      // every tick samples, delta mode, extreme thresholds, both alarms at once
      load_config(make_cfg(16'd0, SAMPLE_DELTA, STARTUP_CODE3, 32'h8000_0000, 32'h7FFF_FFFF,
                           EVENT_BOTH, EVENT_BOTH));
      send_tick(1'b1, 63'd0);
      send_tick(1'b1, COUNT_MAX);
      send_tick(1'b1, 63'd0);
      send_tick(1'b1, 63'd1);
      send_tick(1'b1, 63'd1);
      drain();

      // countdown over several ticks, invalid counter on a tick between samples
      load_config(make_cfg(16'd3, SAMPLE_ABSOLUTE, STARTUP_EITHER, 32'd50, 32'd20,
                           EVENT_TRAP, EVENT_LOG));
      for (int k = 0; k < 8; k++) begin
         send_tick(k != 5, k[0] ? 63'd0 : 63'd100);
      end

      // random phases with varying pressure on both sides
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         case (p % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
            default: begin src_idle_pct = 38; sink_stall_pct = 38; end
         endcase
         load_config(random_setting(p));
         run_random((p == NUM_PHASES - 1) ? 40 : RANDOM_PER_PHASE);
      end

      drain();
      repeat (8) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/sta_pkg.sv
hdl/sta_csr.sv
hdl/sta_core.sv
hdl/sampled_threshold_alarm_top.sv
tb/tb_sampled_threshold_alarm_top.sv
